[rtl/afsc_pkg.sv]
`timescale 1ns / 1ps

package afsc_pkg;

    // Field and register widths
    localparam int FOCUS_BITS = 8;
    localparam int SHARP_BITS = 31;
    localparam int STEP_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (FOCUS_BITS > STEP_W) ? FOCUS_BITS : STEP_W;

    // Lens position as state: one sign bit so the "not yet positioned" mark fits
    localparam int POS_W  = FOCUS_BITS + 1;
    // Working width for position sums: position plus twice the largest step, signed
    localparam int CALC_W = ((FOCUS_BITS > STEP_W) ? FOCUS_BITS : STEP_W) + 3;

    // Threshold is sharpness / 80, done as (x >> 4) / 5 with a reciprocal multiply
    localparam int          TH_DIV       = 80;
    localparam int          TH_PRE_SHIFT = 4;
    localparam int          TH_W         = SHARP_BITS - 6;
    localparam int          RECIP_SHIFT  = 34;
    localparam logic [31:0] RECIP_FIVE   = 32'hCCCC_CCCD;
    localparam int          PRE_W        = SHARP_BITS - TH_PRE_SHIFT;
    localparam int          PROD_W       = PRE_W + 32;

    typedef logic [FOCUS_BITS-1:0]    focus_t;
    typedef logic [SHARP_BITS-1:0]    sharp_t;
    typedef logic [TH_W-1:0]          thresh_t;
    typedef logic [STEP_W-1:0]        step_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [CALC_W-1:0] calc_t;

    // Register reset values
    localparam focus_t      MAX_FOCUS_RST   = '1;
    localparam focus_t      START_LEFT_RST  = FOCUS_BITS'(8);
    localparam logic [6:0]  COARSE_STEP_RST = 7'd20;
    localparam logic [4:0]  FINE_STEP_RST   = 5'd2;
    localparam logic [5:0]  TRACK_STEP_RST  = 6'd8;
    localparam logic [6:0]  WIDE_STEP_RST   = 7'd16;

    typedef enum logic [2:0] {
        PH_COARSE  = 3'd0,
        PH_FINE    = 3'd1,
        PH_HOLD    = 3'd2,
        PH_PROBE_R = 3'd3,
        PH_PROBE_L = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CL_FLAT  = 3'd0,
        CL_LMAX  = 3'd1,
        CL_LEFT  = 3'd2,
        CL_RIGHT = 3'd3,
        CL_WIDE  = 3'd4
    } class_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FOCUS   = 3'd0,
        CFG_START_LEFT  = 3'd1,
        CFG_COARSE_STEP = 3'd2,
        CFG_FINE_STEP   = 3'd3,
        CFG_TRACK_STEP  = 3'd4,
        CFG_WIDE_STEP   = 3'd5
    } cfg_idx_t;

    // Divide by 80: drop four bits, then multiply by the reciprocal of five
    function automatic thresh_t sharp_thresh(input sharp_t h);
        logic [PRE_W-1:0]  x;
        logic [PROD_W-1:0] p;
        x = h[SHARP_BITS-1:TH_PRE_SHIFT];
        p = PROD_W'(x) * PROD_W'(RECIP_FIVE);
        return p[RECIP_SHIFT +: TH_W];
    endfunction

    // Clip a working position to 0..hi
    function automatic focus_t clip_focus(input calc_t v, input focus_t hi);
        calc_t hx;
        hx = {{(CALC_W-FOCUS_BITS){1'b0}}, hi};
        if (v < 0) begin
            return '0;
        end else if (v > hx) begin
            return hi;
        end
        return v[FOCUS_BITS-1:0];
    endfunction

endpackage

[rtl/autofocus_search_controller_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Word
// s_        in         s_valid / s_ready      s_sharpness, s_restart_request
// m_        out        m_valid / m_ready      m_focus_position, m_search_phase
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word in, one word out, through an input register, then the scan or probe
// update and the result register. A new word is taken every cycle unless the
// output stalls; the rate is set by the single update stage, whose longest path
// is the sharpness compare feeding the divide-by-80 multiplier into the threshold
// register. Reset (aresetn low, synchronous) restores the register defaults and
// starts a coarse scan. A stalled result holds in the output register while the
// input register still takes one more word; cfg_ready is always high.

module autofocus_search_controller_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [afsc_pkg::SHARP_BITS-1:0]   s_sharpness,
    input  logic                              s_restart_request,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [afsc_pkg::FOCUS_BITS-1:0]   m_focus_position,
    output logic [2:0]                        m_search_phase,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [afsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int F  = afsc_pkg::FOCUS_BITS;
    localparam int CW = afsc_pkg::CALC_W;
    localparam int PW = afsc_pkg::POS_W;
    localparam int SW = afsc_pkg::STEP_W;

    // Input register
    logic              in_valid_reg;
    afsc_pkg::sharp_t  s_sharp_reg;
    logic              restart_reg;

    // Configuration registers
    afsc_pkg::focus_t  max_focus_reg;
    afsc_pkg::focus_t  start_left_reg;
    logic [6:0]        coarse_step_reg;
    logic [4:0]        fine_step_reg;
    logic [5:0]        track_step_reg;
    logic [6:0]        wide_step_reg;

    // Search state
    afsc_pkg::phase_t  phase_reg, phase_next;
    afsc_pkg::pos_t    focus_now_reg, focus_now_next;
    afsc_pkg::focus_t  scan_right_reg, scan_right_next;
    afsc_pkg::step_t   probe_step_reg, probe_step_next;
    afsc_pkg::sharp_t  held_reg, held_next;
    afsc_pkg::sharp_t  right_reg, right_next;
    afsc_pkg::sharp_t  best_reg, best_next;
    afsc_pkg::pos_t    best_pos_reg, best_pos_next;
    logic              pending_reg, pending_next;
    afsc_pkg::thresh_t thresh_reg, thresh_next;

    // Output register
    logic              m_valid_reg;
    afsc_pkg::focus_t  m_focus_position_reg;
    afsc_pkg::phase_t  m_search_phase_reg;

    logic              advance;
    logic              take;
    logic              wide_mode;
    logic              held_load;
    afsc_pkg::sharp_t  held_src;
    afsc_pkg::sharp_t  best_upd;
    afsc_pkg::pos_t    best_pos_upd;
    afsc_pkg::calc_t   focus_x, best_pos_x, step_x, right_x;
    afsc_pkg::calc_t   coarse_x, fine_x, half_x, focus_calc;
    afsc_pkg::focus_t  fine_lo;
    afsc_pkg::class_t  cls;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid          = m_valid_reg;
    assign m_focus_position = m_focus_position_reg;
    assign m_search_phase   = m_search_phase_reg;

    assign wide_mode = probe_step_reg > {1'b0, track_step_reg};

    afsc_classify u_classify (
        .held      (held_reg),
        .right_s   (right_reg),
        .left_s    (s_sharp_reg),
        .thresh    (thresh_reg),
        .wide_mode (wide_mode),
        .cls       (cls)
    );

    // Best-sample pick and operands widened to the working width
    always_comb begin
        take         = s_sharp_reg >= best_reg;
        best_upd     = take ? s_sharp_reg : best_reg;
        best_pos_upd = take ? focus_now_reg : best_pos_reg;
        focus_x      = {{(CW-PW){focus_now_reg[PW-1]}}, focus_now_reg};
        best_pos_x   = {{(CW-PW){best_pos_upd[PW-1]}}, best_pos_upd};
        step_x       = {{(CW-SW){1'b0}}, probe_step_reg};
        right_x      = {{(CW-F){1'b0}}, scan_right_reg};
        coarse_x     = {{(CW-7){1'b0}}, coarse_step_reg};
        fine_x       = {{(CW-5){1'b0}}, fine_step_reg};
        half_x       = {{(CW-6){1'b0}}, coarse_step_reg[6:1]};
    end

    // Next search state for the word in the input register
    always_comb begin
        phase_next      = phase_reg;
        scan_right_next = scan_right_reg;
        probe_step_next = probe_step_reg;
        right_next      = right_reg;
        best_next       = best_reg;
        best_pos_next   = best_pos_reg;
        pending_next    = pending_reg || restart_reg;
        held_load       = 1'b0;
        held_src        = s_sharp_reg;
        focus_calc      = focus_x;
        fine_lo         = '0;

        case (phase_reg)
            afsc_pkg::PH_COARSE: begin
                best_next     = best_upd;
                best_pos_next = best_pos_upd;
                if (focus_x > right_x - coarse_x) begin
                    // Center the fine window on the best coarse position
                    fine_lo         = afsc_pkg::clip_focus(best_pos_x - half_x, max_focus_reg);
                    scan_right_next = afsc_pkg::clip_focus(best_pos_x + half_x, max_focus_reg);
                    focus_calc      = {{(CW-F){1'b0}}, fine_lo};
                    best_next       = '0;
                    best_pos_next   = '0;
                    phase_next      = afsc_pkg::PH_FINE;
                end else begin
                    focus_calc = focus_x + coarse_x;
                end
            end
            afsc_pkg::PH_FINE: begin
                best_next     = best_upd;
                best_pos_next = best_pos_upd;
                if (focus_x > right_x - fine_x) begin
                    focus_calc      = best_pos_x;
                    held_load       = 1'b1;
                    held_src        = best_upd;
                    probe_step_next = {1'b0, track_step_reg};
                    phase_next      = afsc_pkg::PH_HOLD;
                end else begin
                    focus_calc = focus_x + fine_x;
                end
            end
            afsc_pkg::PH_HOLD: begin
                if (pending_reg || restart_reg) begin
                    // Restart the full search from where the lens stands
                    pending_next    = 1'b0;
                    phase_next      = afsc_pkg::PH_COARSE;
                    scan_right_next = max_focus_reg;
                    best_next       = '0;
                    best_pos_next   = '0;
                end else begin
                    held_load  = 1'b1;
                    held_src   = s_sharp_reg;
                    right_next = '0;
                    focus_calc = focus_x + step_x;
                    phase_next = afsc_pkg::PH_PROBE_R;
                end
            end
            afsc_pkg::PH_PROBE_R: begin
                right_next = s_sharp_reg;
                focus_calc = focus_x - (step_x <<< 1);
                phase_next = afsc_pkg::PH_PROBE_L;
            end
            afsc_pkg::PH_PROBE_L: begin
                case (cls)
                    afsc_pkg::CL_RIGHT: begin
                        focus_calc = focus_x + (step_x <<< 1);
                    end
                    afsc_pkg::CL_LEFT: begin
                        focus_calc = focus_x;
                    end
                    afsc_pkg::CL_WIDE: begin
                        focus_calc      = focus_x + step_x;
                        probe_step_next = wide_step_reg;
                    end
                    default: begin
                        focus_calc      = focus_x + step_x;
                        probe_step_next = {1'b0, track_step_reg};
                    end
                endcase
                phase_next = afsc_pkg::PH_HOLD;
            end
            default: begin
                phase_next = afsc_pkg::PH_HOLD;
            end
        endcase

        focus_now_next = {1'b0, afsc_pkg::clip_focus(focus_calc, max_focus_reg)};
        held_next      = held_load ? held_src : held_reg;
        thresh_next    = held_load ? afsc_pkg::sharp_thresh(held_src) : thresh_reg;
    end

    // Hold the input word until the update stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            s_sharp_reg <= s_sharpness;
            restart_reg <= s_restart_request;
        end
    end

    // Write configuration registers; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_focus_reg   <= afsc_pkg::MAX_FOCUS_RST;
            start_left_reg  <= afsc_pkg::START_LEFT_RST;
            coarse_step_reg <= afsc_pkg::COARSE_STEP_RST;
            fine_step_reg   <= afsc_pkg::FINE_STEP_RST;
            track_step_reg  <= afsc_pkg::TRACK_STEP_RST;
            wide_step_reg   <= afsc_pkg::WIDE_STEP_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                afsc_pkg::CFG_MAX_FOCUS:   max_focus_reg   <= cfg_data[F-1:0];
                afsc_pkg::CFG_START_LEFT:  start_left_reg  <= cfg_data[F-1:0];
                afsc_pkg::CFG_COARSE_STEP: coarse_step_reg <= cfg_data[6:0];
                afsc_pkg::CFG_FINE_STEP:   fine_step_reg   <= cfg_data[4:0];
                afsc_pkg::CFG_TRACK_STEP:  track_step_reg  <= cfg_data[5:0];
                afsc_pkg::CFG_WIDE_STEP:   wide_step_reg   <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the search state and load the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= afsc_pkg::PH_COARSE;
            focus_now_reg  <= '1;
            scan_right_reg <= afsc_pkg::MAX_FOCUS_RST;
            probe_step_reg <= '0;
            held_reg       <= '0;
            right_reg      <= '0;
            best_reg       <= '0;
            best_pos_reg   <= '0;
            pending_reg    <= 1'b0;
            thresh_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg      <= phase_next;
                focus_now_reg  <= focus_now_next;
                scan_right_reg <= scan_right_next;
                probe_step_reg <= probe_step_next;
                held_reg       <= held_next;
                right_reg      <= right_next;
                best_reg       <= best_next;
                best_pos_reg   <= best_pos_next;
                pending_reg    <= pending_next;
                thresh_reg     <= thresh_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            m_focus_position_reg <= focus_now_next[F-1:0];
            m_search_phase_reg   <= phase_next;
        end
    end

`ifndef SYNTHESIS
    a_thresh_matches_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (64'(thresh_reg) * 64'(afsc_pkg::TH_DIV) <= 64'(held_reg)) &&
        (64'(held_reg) < 64'(thresh_reg) * 64'(afsc_pkg::TH_DIV) + 64'(afsc_pkg::TH_DIV)))
        else $error("threshold register out of step with held sharpness");

    a_result_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_search_phase_reg == phase_reg))
        else $error("result phase differs from search phase");

    a_probe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg == afsc_pkg::PH_PROBE_R) |=>
            (phase_reg == afsc_pkg::PH_PROBE_L))
        else $error("right probe not followed by left probe");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(s_sharp_reg)))
        else $error("pending input word lost or changed");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(advance))
        else $error("result word appeared without an update");
`endif

endmodule

[rtl/afsc_classify.sv]
`timescale 1ns / 1ps

module afsc_classify (
    input  afsc_pkg::sharp_t  held,
    input  afsc_pkg::sharp_t  right_s,
    input  afsc_pkg::sharp_t  left_s,
    input  afsc_pkg::thresh_t thresh,
    input  logic              wide_mode,
    output afsc_pkg::class_t  cls
);

    localparam int DW = afsc_pkg::SHARP_BITS + 2;

    logic signed [DW-1:0] held_x;
    logic signed [DW-1:0] right_x;
    logic signed [DW-1:0] left_x;
    logic signed [DW-1:0] th_x;
    logic signed [DW-1:0] dl;
    logic signed [DW-1:0] dr;
    logic                 drop_l, drop_r;
    logic                 big_l, big_r;
    logic                 pos_l, pos_r;
    logic [1:0]           lc, rc;

    // Differences of the two probes against the held sharpness
    always_comb begin
        held_x  = {2'b00, held};
        right_x = {2'b00, right_s};
        left_x  = {2'b00, left_s};
        th_x    = {{(DW-afsc_pkg::TH_W){1'b0}}, thresh};
        dl      = left_x - held_x;
        dr      = right_x - held_x;
        drop_l  = (-dl) >= th_x;
        drop_r  = (-dr) >= th_x;
        big_l   = drop_l || (dl >= th_x);
        big_r   = drop_r || (dr >= th_x);
        pos_l   = dl > 0;
        pos_r   = dr > 0;
        lc      = {1'b0, big_l && pos_l} + {1'b0, big_r && !pos_r};
        rc      = {1'b0, big_l && !pos_l} + {1'b0, big_r && pos_r};
    end

    // Vote on the direction of the slope
    always_comb begin
        if (wide_mode) begin
            cls = (drop_r && drop_l) ? afsc_pkg::CL_LMAX : afsc_pkg::CL_FLAT;
        end else if (!big_l && !big_r) begin
            cls = afsc_pkg::CL_FLAT;
        end else if (drop_r && drop_l) begin
            cls = afsc_pkg::CL_WIDE;
        end else if (lc == rc) begin
            cls = afsc_pkg::CL_FLAT;
        end else if (lc > rc) begin
            cls = afsc_pkg::CL_LEFT;
        end else begin
            cls = afsc_pkg::CL_RIGHT;
        end
    end

endmodule

[tb/sv/tb_autofocus_search_controller_core.sv]
`timescale 1ns / 1ps

module tb_autofocus_search_controller_core;
    import afsc_pkg::*;

    localparam int     IDLE_LIMIT = 1000;
    localparam longint SHARP_MAX  = (longint'(1) << SHARP_BITS) - 1;

    typedef struct {
        sharp_t sharp;
        logic   restart;
    } frame_t;

    typedef struct {
        focus_t focus;
        phase_t phase;
    } lens_cmd_t;

    logic                  aclk              = 1'b0;
    logic                  aresetn           = 1'b0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    sharp_t                s_sharpness       = '0;
    logic                  s_restart_request = 1'b0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    focus_t                m_focus_position;
    logic [2:0]            m_search_phase;
    logic                  cfg_valid         = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index         = '0;
    logic [CFG_DATA_W-1:0] cfg_data          = '0;

    autofocus_search_controller_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sharpness       (s_sharpness),
        .s_restart_request (s_restart_request),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_focus_position  (m_focus_position),
        .m_search_phase    (m_search_phase),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Frames waiting to be sent and lens commands waiting to come back
    frame_t    pending_frames[$];
    lens_cmd_t next_focus_q[$];

    int frames_queued   = 0;
    int frames_accepted = 0;
    int cfg_writes      = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;

    // Shadow registers
    int cur_max, cur_left, cur_coarse, cur_fine, cur_track, cur_wide;

    // Search state
    phase_t search_ph;
    int     lens_pos, scan_lo, scan_hi, probe_dist, peak_pos;
    longint held_sharp, right_sharp, peak_sharp;
    bit     restart_armed;

    function automatic int clamp_lens(input int v);
        if (v > cur_max) return cur_max;
        if (v < 0) return 0;
        return v;
    endfunction

    // Keep the sharpest sample; a tie moves the peak to the later position
    function automatic void note_peak(input longint s);
        if (s >= peak_sharp) begin
            peak_sharp = s;
            peak_pos   = lens_pos;
        end
    endfunction

    // Sort the two probes against held sharpness / 80
    function automatic class_t judge_probes(input longint left_s);
        longint thr, dl, dr, adl, adr;
        int     lc, rc;
        thr = held_sharp / TH_DIV;
        dl  = left_s - held_sharp;
        dr  = right_sharp - held_sharp;
        adl = (dl < 0) ? -dl : dl;
        adr = (dr < 0) ? -dr : dr;
        lc  = 0;
        rc  = 0;
        if (probe_dist > cur_track) return (-dr >= thr && -dl >= thr) ? CL_LMAX : CL_FLAT;
        if (adl < thr && adr < thr) return CL_FLAT;
        if (-dr >= thr && -dl >= thr) return CL_WIDE;
        if (adl >= thr) begin
            if (dl > 0) lc++;
            else rc++;
        end
        if (adr >= thr) begin
            if (dr > 0) rc++;
            else lc++;
        end
        if (lc == rc) return CL_FLAT;
        return (lc > rc) ? CL_LEFT : CL_RIGHT;
    endfunction

    task automatic reset_search();
        cur_max       = int'(MAX_FOCUS_RST);
        cur_left      = int'(START_LEFT_RST);
        cur_coarse    = int'(COARSE_STEP_RST);
        cur_fine      = int'(FINE_STEP_RST);
        cur_track     = int'(TRACK_STEP_RST);
        cur_wide      = int'(WIDE_STEP_RST);
        search_ph     = PH_COARSE;
        lens_pos      = -1;
        scan_lo       = cur_left;
        scan_hi       = cur_max;
        probe_dist    = 0;
        held_sharp    = 0;
        right_sharp   = 0;
        peak_sharp    = 0;
        peak_pos      = 0;
        restart_armed = 1'b0;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (cfg_idx_t'(idx))
            CFG_MAX_FOCUS:   cur_max    = int'(d) & 8'hFF;
            CFG_START_LEFT:  cur_left   = int'(d) & 8'hFF;
            CFG_COARSE_STEP: cur_coarse = int'(d) & 7'h7F;
            CFG_FINE_STEP:   cur_fine   = int'(d) & 5'h1F;
            CFG_TRACK_STEP:  cur_track  = int'(d) & 6'h3F;
            CFG_WIDE_STEP:   cur_wide   = int'(d) & 7'h7F;
            default: ;
        endcase
    endtask

    // Advance the search by one frame and return the next lens command
    task automatic advance_focus_search(input sharp_t sharp, input logic restart,
                                        output lens_cmd_t cmd);
        longint s;
        int     step, half;
        s    = longint'(sharp);
        step = probe_dist;
        if (restart) restart_armed = 1'b1;
        case (search_ph)
            PH_COARSE: begin
                note_peak(s);
                if (lens_pos > scan_hi - cur_coarse) begin
                    half       = cur_coarse / 2;
                    scan_lo    = clamp_lens(peak_pos - half);
                    scan_hi    = clamp_lens(peak_pos + half);
                    lens_pos   = scan_lo;
                    peak_sharp = 0;
                    peak_pos   = 0;
                    search_ph  = PH_FINE;
                end else begin
                    lens_pos += cur_coarse;
                end
            end
            PH_FINE: begin
                note_peak(s);
                if (lens_pos > scan_hi - cur_fine) begin
                    lens_pos   = peak_pos;
                    held_sharp = peak_sharp;
                    probe_dist = cur_track;
                    search_ph  = PH_HOLD;
                end else begin
                    lens_pos += cur_fine;
                end
            end
            PH_HOLD: begin
                // take a pending restart here; the lens stays put
                if (restart_armed) begin
                    restart_armed = 1'b0;
                    search_ph     = PH_COARSE;
                    scan_lo       = cur_left;
                    scan_hi       = cur_max;
                    peak_sharp    = 0;
                    peak_pos      = 0;
                end else begin
                    held_sharp  = s;
                    right_sharp = 0;
                    lens_pos   += step;
                    search_ph   = PH_PROBE_R;
                end
            end
            PH_PROBE_R: begin
                right_sharp = s;
                lens_pos   -= 2 * step;
                search_ph   = PH_PROBE_L;
            end
            default: begin
                case (judge_probes(s))
                    CL_RIGHT: lens_pos += 2 * step;
                    // stay at the left probe
                    CL_LEFT: ;
                    CL_WIDE: begin
                        lens_pos  += step;
                        probe_dist = cur_wide;
                    end
                    default: begin
                        lens_pos  += step;
                        probe_dist = cur_track;
                    end
                endcase
                search_ph = PH_HOLD;
            end
        endcase
        lens_pos  = clamp_lens(lens_pos);
        cmd.focus = focus_t'(lens_pos);
        cmd.phase = search_ph;
    endtask

    // Drive input words in bursts with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin : drv
        frame_t fr;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_frames.size() > 0) begin
                fr = pending_frames.pop_front();
                s_valid           <= 1'b1;
                s_sharpness       <= fr.sharp;
                s_restart_request <= fr.restart;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel: always ready, coin flips, or long stalls
    int rx_mode    = 0;
    int rx_count   = 0;
    int stall_left = 0;

    always @(posedge aclk) begin : rcv
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_mode    = 0;
            rx_count   = 0;
            stall_left = 0;
        end else begin
            rx_count++;
            if (rx_count % 300 == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 20);
                    end
                end
            endcase
        end
    end

    // Track register writes, predict accepted words, check results, watch for a hang
    always @(posedge aclk) begin : mon
        lens_cmd_t cmd;
        lens_cmd_t want;
        bit        moved;
        if (!aresetn) begin
            reset_search();
            next_focus_q.delete();
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
                cfg_writes++;
                moved = 1'b1;
            end
            if (s_valid && s_ready) begin
                advance_focus_search(s_sharpness, s_restart_request, cmd);
                next_focus_q.push_back(cmd);
                frames_accepted++;
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (next_focus_q.size() == 0) begin
                    $display("%0t: unexpected word, focus_position %0d search_phase %0d",
                             $time, m_focus_position, m_search_phase);
                    mismatches++;
                end else begin
                    want = next_focus_q.pop_front();
                    if (m_focus_position !== want.focus) begin
                        $display("%0t: focus_position expected %0d, got %0d",
                                 $time, want.focus, m_focus_position);
                        mismatches++;
                    end
                    if (m_search_phase !== want.phase) begin
                        $display("%0t: search_phase expected %0d, got %0d",
                                 $time, want.phase, m_search_phase);
                        mismatches++;
                    end
                end
            end
            if (moved) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic push_frame(input longint sharp, input logic restart);
        frame_t fr;
        fr.sharp   = sharp_t'(sharp);
        fr.restart = restart;
        pending_frames.push_back(fr);
        frames_queued++;
    endtask

    function automatic longint pick_base();
        case ($urandom_range(0, 3))
            0:       return longint'($urandom) & SHARP_MAX;
            1:       return longint'($urandom_range(0, 200));
            2:       return (longint'($urandom) & SHARP_MAX) >> $urandom_range(1, 24);
            default: return SHARP_MAX - longint'($urandom_range(0, 1000));
        endcase
    endfunction

    // Queue frames in runs around one sharpness level, a few percent apart, so the
    // probes land on both sides of the threshold; mix in some full-range noise
    task automatic queue_frames(input int count);
        longint base, v;
        int     run_left, pct;
        run_left = 0;
        base     = 0;
        repeat (count) begin
            if (run_left == 0) begin
                run_left = $urandom_range(4, 30);
                base     = pick_base();
            end
            run_left--;
            if ($urandom_range(0, 9) == 0) begin
                v = longint'($urandom) & SHARP_MAX;
            end else begin
                pct = int'($urandom_range(0, 80)) - 40;
                v   = base + (base * pct) / 1000;
                if (v < 0) v = 0;
                if (v > SHARP_MAX) v = SHARP_MAX;
            end
            push_frame(v, $urandom_range(0, 29) == 0);
        end
    endtask

    // Block until every queued frame is accepted and answered, then let the pipe drain
    task automatic wait_idle();
        while (frames_accepted != frames_queued || next_focus_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        int seen;
        @(posedge aclk);
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        wait (cfg_writes != seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_setting(input int mx, input int lft, input int crs,
                                 input int fn, input int trk, input int wd);
        write_reg(CFG_MAX_FOCUS, mx);
        write_reg(CFG_START_LEFT, lft);
        write_reg(CFG_COARSE_STEP, crs);
        write_reg(CFG_FINE_STEP, fn);
        write_reg(CFG_TRACK_STEP, trk);
        write_reg(CFG_WIDE_STEP, wd);
    endtask

    initial begin : stim
        longint seed_pts [22];
        seed_pts = '{0, SHARP_MAX, SHARP_MAX, 1, 0, 50, 79, 80, 1000, 1000, 1000,
                     SHARP_MAX - 1, 3, 500, 500, 0, SHARP_MAX, 200, 200, 79, 80, 1};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, ties, tiny values, a restart latched during the scan
        for (int i = 0; i < 22; i++) push_frame(seed_pts[i], i == 1);
        queue_frames(200);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            // Move into tracking first so a new clip limit cannot strand the scan
            for (int k = 0; k < 64 && (search_ph == PH_COARSE || search_ph == PH_FINE); k++) begin
                queue_frames(1);
                wait_idle();
            end
            case (p)
                0: write_setting(255, 0, 64, 16, 32, 64);
                1: write_setting(1, 255, 2, 1, 1, 2);
                2: write_setting(255, 8, 20, 2, 8, 16);
                default: write_setting($urandom_range(0, 1) ? $urandom_range(128, 255)
                                                            : $urandom_range(1, 255),
                                       $urandom_range(0, 255), $urandom_range(2, 64),
                                       $urandom_range(1, 16), $urandom_range(1, 32),
                                       $urandom_range(2, 64));
            endcase
            queue_frames(215);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
